@@ hw/rtl/icr_pkg.sv @@
package icr_pkg;
    localparam int MaxStates = 32;
    localparam int RateW = 32;
    localparam int PopW = 32;
    localparam int WideW = 64;
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] RegSubstepCount = 1'd0;
    localparam logic [CfgIdxW-1:0] RegTimeStep = 1'd1;
    localparam logic signed [WideW-1:0] WideLim = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [WideW-1:0] PopMax = 64'sd2147483647;
    localparam logic signed [WideW-1:0] PopMin = -64'sd2147483648;

    function automatic logic signed [WideW-1:0] clamp_wide(input logic signed [WideW:0] v);
        if (v > $signed({WideLim[WideW-1], WideLim})) return WideLim;
        if (v < -$signed({WideLim[WideW-1], WideLim})) return -WideLim;
        return v[WideW-1:0];
    endfunction

    function automatic logic signed [WideW-1:0] clamp_pop(input logic signed [WideW:0] v);
        if (v > $signed({PopMax[WideW-1], PopMax})) return PopMax;
        if (v < $signed({PopMin[WideW-1], PopMin})) return PopMin;
        return v[WideW-1:0];
    endfunction

    function automatic logic signed [WideW-1:0] add_wide(input logic signed [WideW-1:0] a,
                                                         input logic signed [WideW-1:0] b);
        return clamp_wide((WideW+1)'(a) + (WideW+1)'(b));
    endfunction

    function automatic logic signed [WideW-1:0] add_pop(input logic signed [WideW-1:0] a,
                                                        input logic signed [WideW-1:0] b);
        return clamp_pop((WideW+1)'(a) + (WideW+1)'(b));
    endfunction
endpackage

@@ hw/rtl/ionization_chain_rk4_top.sv @@
// Channel | dir | handshake               | payload
// s_axis  | in  | s_axis_tvalid/tready    | tdata = rate[31:0], tlast = last_rate
// m_axis  | out | m_axis_tvalid/tready    | tdata = cumulative_prob[31:0],
//         |     |                         | tuser = state_index[5:0], tlast = last_result
// cfg     | in  | i_cfg_valid/o_cfg_ready | i_cfg_index (0 substep_count, 1 time_step)
// Each non-final rate is stored in the rate memory. A final rate starts a run: the
// populations are initialized (state 0 to 32'h4000_0000, the rest to zero), a bit-serial
// divider forms the substep length, then each substep has a setup state and walks every
// state through the population memory on one shared 32x32 multiplier (two partial
// products per wide multiply, a divide by six in S_D6A and S_D6B), then each result
// is read and sent. Reset clears control only; the rate memory holds junk until loaded.
// A stalled output holds the sequencer; no item is taken while a run is busy.
module ionization_chain_rk4_top #(
    parameter int MAX_STATES = icr_pkg::MaxStates
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // rate[31:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cumulative_prob[31:0]
    output logic [5:0]  m_axis_tuser,   // state_index[5:0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [icr_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import icr_pkg::*;
    localparam int AW = $clog2(MAX_STATES);
    localparam int CW = $clog2(MAX_STATES + 1);

    typedef enum logic [11:0] {
        S_LOAD = 12'b000000000001, S_DIV  = 12'b000000000010, S_SUB  = 12'b000000000100,
        S_RD   = 12'b000000001000, S_MUL  = 12'b000000010000, S_STEP = 12'b000000100000,
        S_WB   = 12'b000001000000, S_ORD  = 12'b000010000000, S_OUT  = 12'b000100000000,
        S_INIT = 12'b001000000000, S_D6A  = 12'b010000000000, S_D6B  = 12'b100000000000
    } t_state;

    // micro-steps of one state update
    typedef enum logic [3:0] {
        U_K1, U_N2, U_K2, U_N3, U_K3, U_N4, U_K4, U_DLT, U_FEED
    } t_op;

    t_state r_st;
    logic [15:0] r_cnt_cfg;
    logic [31:0] r_ts;
    logic [RateW-1:0] r_rate_mem [MAX_STATES];
    logic signed [PopW-1:0] r_pop_mem [MAX_STATES];
    logic [CW-1:0] r_loaded;
    logic [AW-1:0] r_z;
    logic [15:0] r_sub;
    logic [31:0] r_len;
    logic [63:0] r_rem;
    logic [5:0] r_dcnt;
    logic signed [WideW-1:0] r_feed, r_k1, r_k2, r_k3, r_x, r_acc;
    logic [RateW-1:0] r_w, r_rd_w;
    logic signed [PopW-1:0] r_n, r_rd_n;
    t_op r_op;
    logic [1:0] r_pp;
    logic [63:0] r_m, r_hi, r_lo;
    logic r_neg;
    logic [31:0] r_q;
    logic [59:0] r_dq;
    logic [32:0] r_dn;
    logic r_dneg;

    assign o_cfg_ready = (r_st == S_LOAD);
    assign s_axis_tready = (r_st == S_LOAD);
    assign m_axis_tvalid = (r_st == S_OUT);

    // mul_q16 partial product: one half of the magnitude r_m times r_q, via two 32x32 partial passes
    logic [63:0] pprod;
    assign pprod = (r_pp[0] ? {32'd0, r_m[63:32]} : {32'd0, r_m[31:0]}) * {32'd0, r_q};

    logic signed [WideW-1:0] mres;
    always_comb begin
        logic [63:0] res;
        res = (r_hi[63:46] != 0) ? WideLim : (r_hi << 16) + (r_lo >> 16);
        if (res > WideLim) res = WideLim;
        mres = r_neg ? -$signed(res) : $signed(res);
    end

    logic signed [WideW-1:0] sum_s;
    always_comb begin
        logic signed [WideW-1:0] s;
        s = add_wide(r_k1, r_k2);
        s = add_wide(s, r_k2);
        s = add_wide(s, r_k3);
        s = add_wide(s, r_k3);
        sum_s = add_wide(s, r_x);
    end

    // read port
    logic [AW-1:0] rd_a;
    assign rd_a = r_z;
    always_ff @(posedge i_clk) begin
        r_rd_w <= r_rate_mem[rd_a];
        r_rd_n <= r_pop_mem[rd_a];
    end

    logic signed [WideW-1:0] n_wide, slope_v;
    assign n_wide = WideW'(r_n);
    assign slope_v = add_wide(r_feed, -mres);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD; r_cnt_cfg <= 16'd1; r_ts <= 32'h10000; r_loaded <= '0;
            r_z <= '0; r_pp <= '0; r_op <= U_K1; r_sub <= '0; r_dcnt <= '0;
        end else begin
            case (r_st)
                S_LOAD: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            RegSubstepCount: r_cnt_cfg <= i_cfg_data[15:0];
                            RegTimeStep:     r_ts <= i_cfg_data;
                            default: ;
                        endcase
                    end
                    if (s_axis_tvalid) begin
                        if (r_loaded < CW'(MAX_STATES)) begin
                            r_rate_mem[r_loaded[AW-1:0]] <= s_axis_tdata;
                            r_loaded <= r_loaded + 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_st <= S_INIT; r_z <= '0;
                        end
                    end
                end
                S_INIT: begin  // writes one population entry per cycle
                    r_pop_mem[r_z] <= (r_z == '0) ? 32'sh4000_0000 : '0;
                    if (CW'(r_z) + 1'b1 >= r_loaded) begin
                        r_st <= S_DIV; r_rem <= {32'd0, r_ts}; r_len <= '0; r_dcnt <= '0;
                    end else r_z <= r_z + 1'b1;
                end
                S_DIV: begin  // restoring divide, one quotient bit a cycle
                    if (r_cnt_cfg == 16'd0) begin
                        r_len <= '0; r_st <= S_ORD; r_z <= '0; r_acc <= '0;
                    end else begin
                        logic [63:0] t;
                        t = {r_rem[62:0], 1'b0};
                        if (t[63:32] >= {16'd0, r_cnt_cfg}) begin
                            t[63:32] = t[63:32] - {16'd0, r_cnt_cfg};
                            t[0] = 1'b1;
                        end
                        r_rem <= t;
                        r_dcnt <= r_dcnt + 1'b1;
                        if (r_dcnt == 6'd31) begin
                            r_len <= t[31:0]; r_st <= S_SUB; r_sub <= '0;
                        end
                    end
                end
                S_SUB: begin
                    r_z <= '0; r_feed <= '0; r_st <= S_RD;
                end
                S_RD: r_st <= S_STEP;  // memory latency
                S_STEP: begin  // set up the next multiply of the current micro-step
                    if (r_op == U_K1) begin r_w <= r_rd_w; r_n <= r_rd_n; end
                    case (r_op)
                        U_K1, U_K2, U_K3, U_K4, U_FEED: begin
                            r_q <= (r_op == U_K1) ? r_rd_w : r_w;
                            begin
                                logic signed [WideW-1:0] xv;
                                xv = (r_op == U_K1 || r_op == U_FEED) ?
                                     ((r_op == U_K1) ? WideW'(r_rd_n) : n_wide) : r_x;
                                r_neg <= xv < 0;
                                r_m <= (xv < 0) ? 64'(-xv) : 64'(xv);
                            end
                        end
                        default: begin
                            logic signed [WideW-1:0] xv;
                            xv = (r_op == U_DLT) ? sum_s : r_x;
                            r_q <= r_len;
                            r_neg <= xv < 0;
                            r_m <= (xv < 0) ? 64'(-xv) : 64'(xv);
                        end
                    endcase
                    r_pp <= '0; r_st <= S_MUL;
                end
                S_MUL: begin
                    if (r_pp == 2'd0) r_lo <= pprod;
                    if (r_pp == 2'd1) r_hi <= pprod;
                    r_pp <= r_pp + 1'b1;
                    if (r_pp == 2'd2) begin
                        case (r_op)
                            U_K1: begin
                                r_k1 <= slope_v; r_x <= slope_v; r_op <= U_N2; r_st <= S_STEP;
                            end
                            U_N2: begin
                                r_x <= add_wide(n_wide, mres / 2); r_op <= U_K2; r_st <= S_STEP;
                            end
                            U_K2: begin
                                r_k2 <= slope_v; r_x <= slope_v; r_op <= U_N3; r_st <= S_STEP;
                            end
                            U_N3: begin
                                r_x <= add_wide(n_wide, mres / 2); r_op <= U_K3; r_st <= S_STEP;
                            end
                            U_K3: begin
                                r_k3 <= slope_v; r_x <= slope_v; r_op <= U_N4; r_st <= S_STEP;
                            end
                            U_N4: begin
                                r_x <= add_wide(n_wide, mres); r_op <= U_K4; r_st <= S_STEP;
                            end
                            U_K4: begin r_x <= slope_v; r_op <= U_DLT; r_st <= S_STEP; end
                            U_DLT: begin r_x <= mres; r_op <= U_FEED; r_st <= S_D6A; end
                            default: begin
                                r_feed <= mres; r_op <= U_K1; r_st <= S_WB;
                            end
                        endcase
                    end
                end
                // divide r_x by six toward zero: split the magnitude as a*2^32 + b,
                // with 2^32 = 6*715827882 + 4, then fold 4a + b the same way at 2^16
                S_D6A: begin
                    logic [63:0] dm;
                    dm = r_x[WideW-1] ? 64'(-r_x) : 64'(r_x);
                    r_dneg <= r_x[WideW-1];
                    r_dq <= {30'd0, dm[61:32]} * 60'd715827882;
                    r_dn <= {1'b0, dm[31:0]} + {1'b0, dm[61:32], 2'b00};
                    r_st <= S_D6B;
                end
                S_D6B: begin
                    logic [19:0] de;
                    logic [40:0] dr;
                    logic [63:0] dq;
                    de = {1'b0, r_dn[32:16], 2'b00} + {4'd0, r_dn[15:0]};
                    dr = {21'd0, de} * 41'd1398102;  // reciprocal of six, exact below 2^21
                    dq = 64'(r_dq) + {47'd0, r_dn[32:16]} * 64'd10922 + 64'(dr[40:23]);
                    r_x <= r_dneg ? -$signed(dq) : $signed(dq);
                    r_st <= S_STEP;
                end
                S_WB: begin
                    logic signed [WideW-1:0] np;
                    np = add_pop(n_wide, r_x);
                    r_pop_mem[r_z] <= np[PopW-1:0];
                    if (CW'(r_z) + 1'b1 >= r_loaded) begin
                        r_z <= '0;
                        if (r_sub + 1'b1 >= r_cnt_cfg) begin
                            r_st <= S_ORD; r_acc <= '0;
                        end else begin
                            r_sub <= r_sub + 1'b1; r_st <= S_SUB;
                        end
                    end else begin
                        r_z <= r_z + 1'b1; r_st <= S_RD;
                    end
                end
                S_ORD: r_st <= S_OUT;
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_acc <= add_pop(r_acc, WideW'(r_rd_n));
                        if (CW'(r_z) + 1'b1 >= r_loaded) begin
                            r_st <= S_LOAD; r_loaded <= '0; r_z <= '0;
                        end else begin
                            r_z <= r_z + 1'b1; r_st <= S_ORD;
                        end
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    logic signed [WideW-1:0] out_acc;
    assign out_acc = (r_z == '0) ? WideW'(r_rd_n) : add_pop(r_acc, WideW'(r_rd_n));
    assign m_axis_tdata = out_acc[31:0];
    assign m_axis_tuser = 6'(r_z);
    assign m_axis_tlast = (CW'(r_z) + 1'b1 >= r_loaded);
endmodule
